// File: hdl/stereo_biquad_eq_with_gain_defines.svh
// Assertion macros shared by the equalizer RTL.
`ifndef STEREO_BIQUAD_EQ_WITH_GAIN_DEFINES_SVH
`define STEREO_BIQUAD_EQ_WITH_GAIN_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define SBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that an expression always holds out of reset.
`define SBQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
`endif

// File: hdl/sbq_pkg.sv
// Package: types, constants and helpers of the stereo biquad equalizer.
package sbq_pkg;
    localparam int STAGES_DEF = 4;
    localparam int STAGES_MAX = 16;
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [31:0] COEF_ONE = 32'h1000_0000;
    localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S24_MIN = -24'sh800000;
    localparam int IN_W  = 72;   // op, left_in, right_in, filter_index, coef_slot, coef_value
    localparam int OUT_W = 32;

    typedef struct packed {
        logic        start;
        logic        clear;
        logic [3:0]  stage;
    } lane_ctl_t;

    // Saturate a 64-bit value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage

// File: hdl/stereo_biquad_eq_with_gain.sv
// Top level: stereo cascaded biquad equalizer with volume and balance.
// One lane per channel runs the STAGES biquads through a single registered
// 32x32 multiplier, five products and a retire step per stage. The next
// item is taken the cycle after the result is taken. Coefficient writes
// and history clears give no result. Input is held off while a sample is
// in flight or its result waits at the output register; a waiting result
// does not block anything else once taken.
module stereo_biquad_eq_with_gain #(
    parameter int STAGES = sbq_pkg::STAGES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [7:0]               cfg_data,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // op[1:0], left_in[17:2], right_in[33:18], filter_index[35:34],
    // coef_slot[38:36], coef_value[70:39], zero pad[71]
    input  logic [sbq_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // left_out[15:0], right_out[31:16]
    output logic [sbq_pkg::OUT_W-1:0] m_tdata
);
    import sbq_pkg::*;
    `include "stereo_biquad_eq_with_gain_defines.svh"

    logic [1:0]         op;
    logic [1:0]         fidx;
    logic [2:0]         slot;
    logic [31:0]        cval;
    logic               accept;

    logic [7:0]         volume_reg;
    logic signed [5:0]  balance_reg;
    logic signed [STAGES*5*32-1:0] coef_reg;
    logic               busy_reg;
    logic               ovalid_reg;
    logic [31:0]        odata_reg;

    lane_ctl_t          ctl;
    logic               l_done, r_done, g_done;
    logic signed [23:0] l_res, r_res;
    logic signed [15:0] l_out, r_out;

    assign op     = s_tdata[1:0];
    assign fidx   = s_tdata[35:34];
    assign slot   = s_tdata[38:36];
    assign cval   = s_tdata[70:39];
    assign s_tready = !busy_reg && !ovalid_reg;
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        ctl.start = accept && (op == OP_SAMPLE);
        ctl.clear = accept && (op == OP_CLEAR) && (32'(fidx) < STAGES);
        ctl.stage = 4'(fidx);
    end

    // Configuration registers; index 0 writes volume, index 1 writes balance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg  <= '0;
            balance_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                volume_reg <= cfg_data;
            else
                balance_reg <= cfg_data[5:0];
        end
    end

    // Coefficient table: pass-through at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES*5; i++)
                coef_reg[i*32 +: 32] <= (i % 5 == 0) ? COEF_ONE : 32'd0;
        end
        else if (accept && op == OP_COEF && 32'(fidx) < STAGES && slot < 3'd5)
            coef_reg[(32'(fidx)*5 + 32'(slot))*32 +: 32] <= cval;
    end

    sbq_lane #(.STAGES(STAGES)) u_left (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(s_tdata[17:2]),
        .coefs(coef_reg), .done(l_done), .result(l_res)
    );
    sbq_lane #(.STAGES(STAGES)) u_right (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(s_tdata[33:18]),
        .coefs(coef_reg), .done(r_done), .result(r_res)
    );

    // Merge: apply gain to both lanes once they finish together.
    sbq_gain u_gain (
        .clk(clk), .rst_n(rst_n), .go(l_done), .volume(volume_reg),
        .balance(balance_reg), .left_s(l_res), .right_s(r_res),
        .done(g_done), .left_out(l_out), .right_out(r_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start)
                busy_reg <= 1'b1;
            else if (g_done)
                busy_reg <= 1'b0;
            if (g_done)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_done)
            odata_reg <= {r_out, l_out};
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    `SBQ_ASSERT_ALWAYS(a_lanes_lockstep, clk, rst_n, l_done == r_done, "lanes out of step")
    `SBQ_ASSERT_NEXT(a_no_accept_busy, clk, rst_n, ctl.start, !s_tready, "accepted while busy")
    `SBQ_ASSERT_ALWAYS(a_done_busy, clk, rst_n, !g_done || busy_reg, "result without sample")
endmodule

// File: hdl/sbq_lane.sv
// One channel lane: cascade of biquads over one shared multiplier.
module sbq_lane #(
    parameter int STAGES = sbq_pkg::STAGES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sbq_pkg::lane_ctl_t                      ctl,
    input  logic signed [15:0]                      sample,
    input  logic signed [STAGES*5*32-1:0]           coefs,
    output logic                                    done,
    output logic signed [23:0]                      result
);
    import sbq_pkg::*;
    localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic signed [23:0] x1_reg [STAGES];
    logic signed [23:0] x2_reg [STAGES];
    logic signed [31:0] y1_reg [STAGES];
    logic signed [31:0] y2_reg [STAGES];

    logic               busy_reg, busy_next;
    logic [SW-1:0]      st_reg, st_next;
    logic [2:0]         term_reg, term_next;
    logic               mul_v_reg;
    logic [2:0]         mul_t_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [23:0] x_reg;
    logic               fin_reg;
    logic               done_reg;
    logic signed [23:0] result_reg;

    logic [2:0]         t_sel;
    logic signed [31:0] c_sel;
    logic signed [31:0] d_sel;
    logic signed [63:0] term_val;
    logic signed [63:0] acc_sum;
    logic signed [63:0] tz;
    logic signed [23:0] out24;
    logic signed [31:0] y_new;

    // Terms 0..4 issue products; term 5 retires the stage so the next
    // stage reads its fresh input.
    always_comb
    begin
        t_sel = (term_reg > 3'd4) ? 3'd4 : term_reg;
        c_sel = coefs[(32'(st_reg)*5 + 32'(t_sel))*32 +: 32];
        unique case (t_sel)
            3'd0:    d_sel = 32'(x_reg);
            3'd1:    d_sel = 32'(x1_reg[st_reg]);
            3'd2:    d_sel = 32'(x2_reg[st_reg]);
            3'd3:    d_sel = y1_reg[st_reg];
            default: d_sel = y2_reg[st_reg];
        endcase
    end

    always_comb
    begin
        if (mul_t_reg >= 3'd3)
            term_val = -(prod_reg >>> 9);
        else
            term_val = prod_reg;
        acc_sum = acc_reg + term_val;
        // Truncate toward zero to sample units.
        if (acc_sum < 0)
            tz = -((-acc_sum) >>> 28);
        else
            tz = acc_sum >>> 28;
        if (tz > 64'(S24_MAX))
            out24 = S24_MAX;
        else if (tz < 64'(S24_MIN))
            out24 = S24_MIN;
        else
            out24 = tz[23:0];
        y_new = sat32(acc_sum >>> 19);
    end

    always_comb
    begin
        busy_next = busy_reg;
        st_next   = st_reg;
        term_next = term_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            st_next   = '0;
            term_next = '0;
        end
        else if (busy_reg)
        begin
            if (term_reg == 3'd5)
            begin
                term_next = '0;
                if (32'(st_reg) == STAGES - 1)
                    busy_next = 1'b0;
                else
                    st_next = st_reg + 1'b1;
            end
            else
                term_next = term_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            st_reg    <= '0;
            term_reg  <= '0;
            mul_v_reg <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < STAGES; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else
        begin
            busy_reg  <= busy_next;
            st_reg    <= st_next;
            term_reg  <= term_next;
            mul_v_reg <= busy_reg && (term_reg != 3'd5);
            mul_t_reg <= term_reg;
            fin_reg   <= busy_reg && (term_reg == 3'd4) && (32'(st_reg) == STAGES - 1);
            done_reg  <= fin_reg;
            if (ctl.start)
                x_reg <= 24'(sample);
            if (busy_reg)
                prod_reg <= 64'(c_sel) * 64'(d_sel);
            if (ctl.clear)
            begin
                x1_reg[ctl.stage[SW-1:0]] <= '0;
                x2_reg[ctl.stage[SW-1:0]] <= '0;
                y1_reg[ctl.stage[SW-1:0]] <= '0;
                y2_reg[ctl.stage[SW-1:0]] <= '0;
            end
            if (mul_v_reg)
            begin
                if (mul_t_reg == 3'd0)
                    acc_reg <= prod_reg;
                else
                    acc_reg <= acc_sum;
                // Last term of a stage: retire history, hand output on.
                if (mul_t_reg == 3'd4)
                begin
                    x2_reg[st_reg] <= x1_reg[st_reg];
                    x1_reg[st_reg] <= x_reg;
                    y2_reg[st_reg] <= y1_reg[st_reg];
                    y1_reg[st_reg] <= y_new;
                    x_reg      <= out24;
                    result_reg <= out24;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

// File: hdl/sbq_gain.sv
// Merge stage: per-channel volume/balance gain and 16-bit saturation.
module sbq_gain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [7:0]          volume,
    input  logic signed [5:0]   balance,
    input  logic signed [23:0]  left_s,
    input  logic signed [23:0]  right_s,
    output logic                done,
    output logic signed [15:0]  left_out,
    output logic signed [15:0]  right_out
);
    import sbq_pkg::*;

    logic [7:0]         vol;
    logic signed [5:0]  b;
    logic [8:0]         base;
    logic [13:0]        bs;
    logic [8:0]         gl, gr;
    logic signed [9:0]  gl_reg, gr_reg;
    logic signed [23:0] ls_reg, rs_reg;
    logic               v1_reg, done_reg;
    logic signed [15:0] lo_reg, ro_reg;
    logic signed [33:0] pl, pr;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] p);
        logic signed [33:0] v;
        v = p >>> 8;
        if (v > 34'sd32767)
            return 16'sh7FFF;
        else if (v < -34'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    always_comb
    begin
        vol  = (volume > 8'd254) ? 8'd254 : volume;
        b    = (balance < -6'sd16) ? -6'sd16 : ((balance > 6'sd16) ? 6'sd16 : balance);
        // vol*256/254 is vol + vol/127, and vol/127 is 0, 1 or 2 here.
        base = 9'(vol) + ((vol >= 8'd254) ? 9'd2 : ((vol >= 8'd127) ? 9'd1 : 9'd0));
        gl   = base;
        gr   = base;
        bs   = '0;
        if (b < 0)
        begin
            bs = 14'(base) * 14'(6'sd16 + b);
            gr = bs[12:4];
        end
        else if (b > 0)
        begin
            bs = 14'(base) * 14'(6'sd16 - b);
            gl = bs[12:4];
        end
        pl = 34'(ls_reg) * 34'(gl_reg);
        pr = 34'(rs_reg) * 34'(gr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= go;
            done_reg <= v1_reg;
            if (go)
            begin
                ls_reg <= left_s;
                rs_reg <= right_s;
                gl_reg <= 10'(gl);
                gr_reg <= 10'(gr);
            end
            if (v1_reg)
            begin
                lo_reg <= sat16(pl);
                ro_reg <= sat16(pr);
            end
        end
    end

    assign done      = done_reg;
    assign left_out  = lo_reg;
    assign right_out = ro_reg;
endmodule
